// ----- src/clipped_color_key_blit_assert.svh -----
// ---------------------------------------------------------------------------
// clipped color key blit assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef CLIPPED_COLOR_KEY_BLIT_ASSERT_SVH
`define CLIPPED_COLOR_KEY_BLIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CCB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CCB_ASSERT_IMP(label, clk, rst, ante, cons)
`define CCB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/ccb_pkg.sv -----
// ---------------------------------------------------------------------------
// ccb_pkg
// shared types and constants of the clipped color key blit
// ---------------------------------------------------------------------------
`default_nettype none

package ccb_pkg;

  localparam int REG_BITS      = 12;
  localparam int COORD_BITS    = 12;
  localparam int SUM_BITS      = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 1;
  localparam int CMP_BITS      = ((COORD_BITS + 1 > REG_BITS) ? COORD_BITS + 1 : REG_BITS);
  localparam int ADDR_BITS     = 24;
  localparam int PIX_BITS      = 8;
  localparam int NIB_BITS      = 4;
  localparam int KEY_BITS      = 5;
  localparam int PAL_BITS      = 64;
  localparam int APB_ADDR_BITS = 6;
  localparam int APB_DATA_BITS = 64;
  localparam int REG_IDX_BITS  = 3;
  localparam int REG_LSB       = 3;

  localparam logic [REG_BITS-1:0] FB_WIDTH_RST   = 12'd320;
  localparam logic [REG_BITS-1:0] FB_HEIGHT_RST  = 12'd200;
  localparam logic [REG_BITS-1:0] RECT_WIDTH_RST = 12'd1;
  localparam logic [KEY_BITS-1:0] KEY_COLOR_RST  = 5'h1f;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FB_WIDTH,
    REG_FB_HEIGHT,
    REG_DST_X,
    REG_DST_Y,
    REG_RECT_WIDTH,
    REG_KEY_COLOR,
    REG_REMAP_ENABLE,
    REG_PALETTE_MAP
  } reg_idx_t;

  typedef struct packed {
    logic [REG_BITS-1:0]        fb_width;
    logic [REG_BITS-1:0]        fb_height;
    logic [REG_BITS-1:0]        dst_x;
    logic [REG_BITS-1:0]        dst_y;
    logic [REG_BITS-1:0]        rect_width;
    logic signed [KEY_BITS-1:0] key_color;
    logic                       remap_enable;
    logic [PAL_BITS-1:0]        palette_map;
  } cfg_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                last;
    logic [SUM_BITS-1:0] col;
    logic [SUM_BITS-1:0] row;
  } item_t;

endpackage

`default_nettype wire

// ----- src/clipped_color_key_blit.sv -----
// ---------------------------------------------------------------------------
// clipped_color_key_blit
// color keyed rectangle blit with framebuffer clipping and palette remap
// ---------------------------------------------------------------------------
// Source pixels of one rectangle enter in row-major order on the s_ stream,
// with s_tlast on the final pixel; the column counter wraps at rect_width
// into the row counter, and both return to zero after a tlast transaction.
// Each input transaction yields exactly one m_ transaction: m_tuser is the
// write enable, m_tdata carries the framebuffer address and the pixel to
// store (both zero when no write), m_tlast copies the input tlast.
// Each transaction passes one input register with the destination coordinate
// and one result register after the clip, key, remap and row*width+column
// logic (one 12x12 multiply). Throughput is one pixel per cycle while the
// receiver is ready. When the receiver stalls, the result register holds and
// the input register takes one more pixel only if it is empty; then s_tready
// stays low until the result is taken.
// Reset clears both counters and the pipeline and loads register defaults.
// Registers are written over the apb port at byte address 8*index; the user
// writes them only while the stream is idle, which the block does not enforce.
// ---------------------------------------------------------------------------
`default_nettype none
`include "clipped_color_key_blit_assert.svh"

module clipped_color_key_blit (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       psel,
  input  wire logic                                       penable,
  input  wire logic                                       pwrite,
  input  wire logic [ccb_pkg::APB_ADDR_BITS-1:0]          paddr,
  input  wire logic [ccb_pkg::APB_DATA_BITS-1:0]          pwdata,
  output logic      [ccb_pkg::APB_DATA_BITS-1:0]          prdata,
  output logic                                            pready,
  input  wire logic                                       s_tvalid,
  output logic                                            s_tready,
  // source_pixel
  input  wire logic [ccb_pkg::PIX_BITS-1:0]               s_tdata,
  input  wire logic                                       s_tlast,
  output logic                                            m_tvalid,
  input  wire logic                                       m_tready,
  // write_address, pixel_out
  output logic [ccb_pkg::ADDR_BITS+ccb_pkg::PIX_BITS-1:0] m_tdata,
  output logic                                            m_tlast,
  // write_enable
  output logic                                            m_tuser
);
  import ccb_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  dn_ready;

  ccb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccb_coord u_coord (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .dn_ready   (dn_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  ccb_pixel u_pixel (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .dn_ready   (dn_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  `CCB_ASSERT_IMP(a_nowrite_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `CCB_ASSERT_IMP(a_remap_nibble, clk, rst, m_tvalid && m_tuser && cfg.remap_enable, m_tdata[ADDR_BITS+PIX_BITS-1:ADDR_BITS+NIB_BITS] == '0)
  `CCB_ASSERT_IMP(a_stall_blocks, clk, rst, m_tvalid && !m_tready && item_valid, !s_tready)
  `CCB_ASSERT_NEXT(a_item_moves, clk, rst, item_valid && dn_ready, m_tvalid)

endmodule

`default_nettype wire

// ----- src/ccb_cfg.sv -----
// ---------------------------------------------------------------------------
// ccb_cfg
// apb register file holding blit geometry, color key and palette
// ---------------------------------------------------------------------------
`default_nettype none

module ccb_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ccb_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [ccb_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [ccb_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  output ccb_pkg::cfg_t                           cfg
);
  import ccb_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[REG_LSB +: REG_IDX_BITS]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fb_width     <= FB_WIDTH_RST;
      cfg.fb_height    <= FB_HEIGHT_RST;
      cfg.dst_x        <= '0;
      cfg.dst_y        <= '0;
      cfg.rect_width   <= RECT_WIDTH_RST;
      cfg.key_color    <= KEY_COLOR_RST;
      cfg.remap_enable <= 1'b0;
      cfg.palette_map  <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_FB_WIDTH:     cfg.fb_width     <= pwdata[REG_BITS-1:0];
        REG_FB_HEIGHT:    cfg.fb_height    <= pwdata[REG_BITS-1:0];
        REG_DST_X:        cfg.dst_x        <= pwdata[REG_BITS-1:0];
        REG_DST_Y:        cfg.dst_y        <= pwdata[REG_BITS-1:0];
        REG_RECT_WIDTH:   cfg.rect_width   <= pwdata[REG_BITS-1:0];
        REG_KEY_COLOR:    cfg.key_color    <= pwdata[KEY_BITS-1:0];
        REG_REMAP_ENABLE: cfg.remap_enable <= pwdata[0];
        REG_PALETTE_MAP:  cfg.palette_map  <= pwdata[PAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FB_WIDTH:     prdata = APB_DATA_BITS'(cfg.fb_width);
      REG_FB_HEIGHT:    prdata = APB_DATA_BITS'(cfg.fb_height);
      REG_DST_X:        prdata = APB_DATA_BITS'(cfg.dst_x);
      REG_DST_Y:        prdata = APB_DATA_BITS'(cfg.dst_y);
      REG_RECT_WIDTH:   prdata = APB_DATA_BITS'(cfg.rect_width);
      REG_KEY_COLOR:    prdata = APB_DATA_BITS'(unsigned'(cfg.key_color));
      REG_REMAP_ENABLE: prdata = APB_DATA_BITS'(cfg.remap_enable);
      REG_PALETTE_MAP:  prdata = APB_DATA_BITS'(cfg.palette_map);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/ccb_coord.sv -----
// ---------------------------------------------------------------------------
// ccb_coord
// column and row counters and the input register with destination coordinates
// ---------------------------------------------------------------------------
`default_nettype none

module ccb_coord (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ccb_pkg::cfg_t                 cfg,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ccb_pkg::PIX_BITS-1:0]  s_tdata,
  input  wire logic                          s_tlast,
  input  wire logic                          dn_ready,
  output logic                               item_valid,
  output ccb_pkg::item_t                     item
);
  import ccb_pkg::*;

  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] column_count_next;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] row_count_next;
  logic [COORD_BITS:0]   col_inc;
  logic                  load;
  logic                  item_valid_next;

  assign s_tready = !item_valid || dn_ready;
  assign load     = s_tvalid && s_tready;
  assign col_inc  = {1'b0, column_count} + (COORD_BITS + 1)'(1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (load) begin
      if (s_tlast) begin
        column_count_next = '0;
        row_count_next    = '0;
      end else if (CMP_BITS'(col_inc) >= CMP_BITS'(cfg.rect_width)) begin
        column_count_next = '0;
        row_count_next    = row_count + COORD_BITS'(1);
      end else begin
        column_count_next = col_inc[COORD_BITS-1:0];
      end
    end
    if (load) begin
      item_valid_next = 1'b1;
    end else if (dn_ready) begin
      item_valid_next = 1'b0;
    end else begin
      item_valid_next = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      item_valid   <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      item_valid   <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.pixel <= s_tdata;
      item.last  <= s_tlast;
      item.col   <= SUM_BITS'(cfg.dst_x) + SUM_BITS'(column_count);
      item.row   <= SUM_BITS'(cfg.dst_y) + SUM_BITS'(row_count);
    end
  end

endmodule

`default_nettype wire

// ----- src/ccb_pixel.sv -----
// ---------------------------------------------------------------------------
// ccb_pixel
// clipping, color key test, palette remap, address and the result register
// ---------------------------------------------------------------------------
`default_nettype none

module ccb_pixel (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire ccb_pkg::cfg_t                            cfg,
  input  wire logic                                     item_valid,
  input  wire ccb_pkg::item_t                           item,
  output logic                                          dn_ready,
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  output logic [ccb_pkg::ADDR_BITS+ccb_pkg::PIX_BITS-1:0] m_tdata,
  output logic                                          m_tlast,
  output logic                                          m_tuser
);
  import ccb_pkg::*;

  logic                    in_frame;
  logic                    keyed;
  logic                    we;
  logic [2*REG_BITS-1:0]   prod;
  logic [ADDR_BITS-1:0]    addr;
  logic [PIX_BITS-1:0]     pout;
  logic [NIB_BITS-1:0]     pal_entry;
  logic                    take;
  logic                    m_tvalid_next;

  assign dn_ready = !m_tvalid || m_tready;
  assign take     = item_valid && dn_ready;

  assign in_frame  = (item.col < SUM_BITS'(cfg.fb_width)) &&
                     (item.row < SUM_BITS'(cfg.fb_height));
  assign keyed     = !cfg.key_color[KEY_BITS-1] &&
                     (item.pixel == PIX_BITS'(cfg.key_color[NIB_BITS-1:0]));
  assign we        = in_frame && !keyed;
  assign prod      = item.row[REG_BITS-1:0] * cfg.fb_width;
  assign pal_entry = cfg.palette_map[{item.pixel[NIB_BITS-1:0], 2'b00} +: NIB_BITS];

  always_comb begin
    addr = '0;
    pout = '0;
    if (we) begin
      addr = ADDR_BITS'(prod) + ADDR_BITS'(item.col);
      pout = cfg.remap_enable ? PIX_BITS'(pal_entry) : item.pixel;
    end
    if (take) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {pout, addr};
      m_tuser <= we;
      m_tlast <= item.last;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking testbench of the clipped color key blit
// ---------------------------------------------------------------------------
// Source pixels go in on the s_ stream while a cycle model of the blit keeps
// its own column and row counters and register copies, and predicts each
// framebuffer write. A monitor compares every m_ transaction with the oldest
// predicted write. Registers are set over apb between phases, with the
// stream drained. Directed tests cover defaults, coordinate extremes, color
// keying, palette remap, zero sizes and width shrink; a
// backpressure test and random rectangles with random idling follow.
// ---------------------------------------------------------------------------

module tb_top;

  import ccb_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int REPORT_LIMIT   = 40;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 40;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]  pix;
    logic                 last;
  } blit_write_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]             paddr = '0;
  logic [APB_DATA_BITS-1:0]             pwdata = '0;
  logic [APB_DATA_BITS-1:0]             prdata;
  logic                                 pready;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [PIX_BITS-1:0]                  s_tdata = '0;   // source_pixel
  logic                                 s_tlast = 1'b0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [ADDR_BITS+PIX_BITS-1:0]        m_tdata;        // write_address, pixel_out
  logic                                 m_tlast;
  logic                                 m_tuser;        // write_enable

  cfg_t                  blit_cfg;
  logic [COORD_BITS-1:0] col_cnt;
  logic [COORD_BITS-1:0] row_cnt;
  blit_write_t           expected_writes[$];

  int   fail_count = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  int   gap_max = 0;
  int   stall_max = 0;
  int   hold_len = 0;
  logic hold_sink = 1'b0;

  clipped_color_key_blit DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // blit model: one predicted write per accepted pixel
  function automatic blit_write_t predict_write(input logic [PIX_BITS-1:0] pix,
                                                input logic last);
    blit_write_t w;
    int unsigned col;
    int unsigned row;
    int unsigned nxt;
    logic        in_frame;
    logic        keyed;
    col      = blit_cfg.dst_x + col_cnt;
    row      = blit_cfg.dst_y + row_cnt;
    in_frame = (col < blit_cfg.fb_width) && (row < blit_cfg.fb_height);
    keyed    = !blit_cfg.key_color[KEY_BITS-1] &&
               (pix == {4'h0, blit_cfg.key_color[3:0]});
    w.we   = in_frame && !keyed;
    w.addr = '0;
    w.pix  = '0;
    w.last = last;
    if (w.we) begin
      w.addr = ADDR_BITS'(row * blit_cfg.fb_width + col);
      w.pix  = blit_cfg.remap_enable ?
               {4'h0, blit_cfg.palette_map[pix[3:0]*NIB_BITS +: NIB_BITS]} : pix;
    end
    if (last) begin
      col_cnt = '0;
      row_cnt = '0;
    end else begin
      nxt = col_cnt + 1;
      if (nxt >= blit_cfg.rect_width) begin
        col_cnt = '0;
        row_cnt = row_cnt + 1'b1;
      end else begin
        col_cnt = COORD_BITS'(nxt);
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned act_v);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
  endtask

  always @(posedge clk) begin : write_monitor
    blit_write_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_writes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $error("transaction with no write expected: addr 0x%0h", m_tdata[ADDR_BITS-1:0]);
      end else begin
        exp_w = expected_writes.pop_front();
        if (m_tuser !== exp_w.we)
          report_mismatch("write_enable", exp_w.we, m_tuser);
        if (m_tdata[ADDR_BITS-1:0] !== exp_w.addr)
          report_mismatch("write_address", exp_w.addr, m_tdata[ADDR_BITS-1:0]);
        if (m_tdata[ADDR_BITS +: PIX_BITS] !== exp_w.pix)
          report_mismatch("pixel_out", exp_w.pix, m_tdata[ADDR_BITS +: PIX_BITS]);
        if (m_tlast !== exp_w.last)
          report_mismatch("last_out", exp_w.last, m_tlast);
      end
    end
  end

  // receiver: ready and stall runs, or one long hold on request
  initial begin : sink_pattern
    int   run_left;
    logic ready_now;
    run_left  = 0;
    ready_now = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_sink = 1'b0;
      end else begin
        if (run_left == 0) begin
          ready_now = (stall_max == 0) ? 1'b1 : !ready_now;
          run_left  = ready_now ? $urandom_range(1, 16) : $urandom_range(1, stall_max);
        end
        run_left--;
        m_tready <= ready_now;
      end
    end
  end

  task automatic reset_model();
    blit_cfg.fb_width     = FB_WIDTH_RST;
    blit_cfg.fb_height    = FB_HEIGHT_RST;
    blit_cfg.dst_x        = '0;
    blit_cfg.dst_y        = '0;
    blit_cfg.rect_width   = RECT_WIDTH_RST;
    blit_cfg.key_color    = KEY_COLOR_RST;
    blit_cfg.remap_enable = 1'b0;
    blit_cfg.palette_map  = '0;
    col_cnt = '0;
    row_cnt = '0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_FB_WIDTH:     blit_cfg.fb_width     = value[REG_BITS-1:0];
      REG_FB_HEIGHT:    blit_cfg.fb_height    = value[REG_BITS-1:0];
      REG_DST_X:        blit_cfg.dst_x        = value[REG_BITS-1:0];
      REG_DST_Y:        blit_cfg.dst_y        = value[REG_BITS-1:0];
      REG_RECT_WIDTH:   blit_cfg.rect_width   = value[REG_BITS-1:0];
      REG_KEY_COLOR:    blit_cfg.key_color    = value[KEY_BITS-1:0];
      REG_REMAP_ENABLE: blit_cfg.remap_enable = value[0];
      REG_PALETTE_MAP:  blit_cfg.palette_map  = value[PAL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned fbw, input int unsigned fbh,
                              input int unsigned dx, input int unsigned dy,
                              input int unsigned rw);
    write_reg(REG_FB_WIDTH, APB_DATA_BITS'(fbw));
    write_reg(REG_FB_HEIGHT, APB_DATA_BITS'(fbh));
    write_reg(REG_DST_X, APB_DATA_BITS'(dx));
    write_reg(REG_DST_Y, APB_DATA_BITS'(dy));
    write_reg(REG_RECT_WIDTH, APB_DATA_BITS'(rw));
  endtask

  task automatic set_pixel_mode(input logic [KEY_BITS-1:0] key, input logic remap,
                                input logic [PAL_BITS-1:0] palette);
    write_reg(REG_KEY_COLOR, APB_DATA_BITS'(key));
    write_reg(REG_REMAP_ENABLE, APB_DATA_BITS'(remap));
    write_reg(REG_PALETTE_MAP, palette);
  endtask

  // one source pixel transaction, with bursts and gaps
  task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_writes.push_back(predict_write(pix, last));
    @(negedge clk);
  endtask

  task automatic finish_phase();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int unsigned pick_extent();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 4095;
      2:       return 1;
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic logic [PIX_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return {4'h0, blit_cfg.key_color[3:0]};
      1:       return PIX_BITS'($urandom_range(0, 15));
      default: return PIX_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'ha5, 1'b1);
    finish_phase();
  endtask

  task automatic test_coordinate_extremes();
    set_geometry(4095, 4095, 4095, 4095, 4095);
    send_pixel(8'h5a, 1'b1);
    finish_phase();
    set_geometry(4095, 4095, 4094, 4094, 2);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b0);
    send_pixel(8'hfe, 1'b1);
    finish_phase();
  endtask

  task automatic test_color_key();
    set_geometry(320, 200, 3, 4, 4);
    set_pixel_mode(5'd5, 1'b0, '0);
    send_pixel(8'h05, 1'b0);
    send_pixel(8'h15, 1'b1);
    finish_phase();
    write_reg(REG_KEY_COLOR, APB_DATA_BITS'(5'd0));
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h10, 1'b1);
    finish_phase();
    // negative key other than all ones: no keying
    write_reg(REG_KEY_COLOR, APB_DATA_BITS'(5'h10));
    send_pixel(8'h10, 1'b0);
    send_pixel(8'h00, 1'b1);
    finish_phase();
    write_reg(REG_KEY_COLOR, APB_DATA_BITS'(5'd15));
    send_pixel(8'h0f, 1'b1);
    finish_phase();
  endtask

  task automatic test_palette_remap();
    set_pixel_mode(5'h1f, 1'b1, 64'hfedc_ba98_7654_3210);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h3c, 1'b1);
    finish_phase();
    set_pixel_mode(5'd7, 1'b1, 64'hffff_ffff_ffff_ffff);
    send_pixel(8'h07, 1'b0);
    send_pixel(8'h87, 1'b1);
    finish_phase();
    write_reg(REG_REMAP_ENABLE, APB_DATA_BITS'(1'b0));
  endtask

  task automatic test_zero_sizes();
    set_geometry(0, 200, 0, 0, 0);
    send_pixel(8'h11, 1'b0);
    send_pixel(8'h22, 1'b1);
    finish_phase();
    set_geometry(320, 0, 0, 0, 3);
    send_pixel(8'h33, 1'b1);
    finish_phase();
    // zero rectangle width steps one row per pixel
    set_geometry(16, 16, 2, 2, 0);
    send_pixel(8'h44, 1'b0);
    send_pixel(8'h55, 1'b1);
    finish_phase();
  endtask

  task automatic test_width_shrink();
    set_geometry(64, 64, 1, 1, 8);
    repeat (5) send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'b0);
    finish_phase();
    write_reg(REG_RECT_WIDTH, APB_DATA_BITS'(2));
    send_pixel(8'h81, 1'b0);
    send_pixel(8'h82, 1'b0);
    send_pixel(8'h83, 1'b1);
    finish_phase();
  endtask

  task automatic test_backpressure();
    gap_max   = 0;
    stall_max = 3;
    set_geometry(40, 30, 5, 5, 7);
    hold_len  = 300;
    hold_sink = 1'b1;
    repeat (40) send_pixel(pick_pixel(), 1'b0);
    send_pixel(pick_pixel(), 1'b1);
    finish_phase();
  endtask

  task automatic test_random_rectangles();
    int unsigned fbw;
    int unsigned fbh;
    int unsigned dx;
    int unsigned dy;
    int unsigned rw;
    int          sent;
    int          len;
    int          noise;
    logic        last;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
      stall_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 12);
      fbw = pick_extent();
      fbh = pick_extent();
      dx  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 50);
      dy  = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 50);
      case ($urandom_range(0, 7))
        0:       rw = 0;
        1:       rw = 4095;
        default: rw = $urandom_range(1, 12);
      endcase
      set_geometry(fbw, fbh, dx, dy, rw);
      set_pixel_mode(KEY_BITS'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                     {$urandom, $urandom});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 5) * ((rw == 0) ? 1 : rw);
        if (len > 48)
          len = $urandom_range(1, 48);
        noise = $urandom_range(0, 9);
        if (noise == 0)
          len = $urandom_range(1, len);
        for (int i = 0; i < len; i++) begin
          last = (i == len - 1) && (noise != 1);
          if (noise == 2 && $urandom_range(0, 7) == 0)
            last = 1'b1;
          send_pixel(pick_pixel(), last);
        end
        sent += len;
      end
      finish_phase();
    end
  endtask

  initial begin
    reset_model();
    gap_max   = 4;
    stall_max = 6;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_coordinate_extremes();
    test_color_key();
    test_palette_remap();
    test_zero_sizes();
    test_width_shrink();
    test_backpressure();
    test_random_rectangles();
    if (fail_count == 0 && expected_writes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
